### hdl/tcw_pkg.sv
// tcw_pkg: shared types and constants for the text console writer.
// No dependencies; imported by tcw_cell_ram and text_console_writer.
package tcw_pkg;

    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_RD     = 8'b0000_1000,
        S_SCR_RD = 8'b0001_0000,
        S_SCR_WR = 8'b0010_0000,
        S_FILL   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

endpackage

### hdl/text_console_writer.sv
// text_console_writer: text-mode console engine, sequencer around one cell store.
// Depends on tcw_pkg and tcw_cell_ram.
//
// Usage:
//   A request is transferred at a rising edge with start high and busy low.
//   Fields: i_req_type (write char / clear / read), i_char_code, i_color,
//   i_cell_index. busy stays high until the request has been served.
//   Each request gives one result: o_strobe is high for exactly one cycle
//   with o_cursor_pos and o_cell_data valid. The receiver cannot stall.
// Request handling (S = NUM_ROWS*NUM_COLS, C = NUM_COLS):
//   null char, printable char, newline, unused type: EXEC then DONE; busy
//   is low again while the strobe is high.  Read: EXEC, RD, then DONE.
//   Clear: fills all S cells (one cell written per cycle), then DONE.
//   Scroll (newline or wrap on the last row): moves S - C cells up one row,
//   each moved cell takes a read then a write, then fills the last C cells.
// Reset: synchronous, active low. After reset the block sweeps the store to
//   zero, one cell per cycle, with busy high; cursor and attribute are cleared.
module text_console_writer #(
    parameter int NUM_ROWS = 25,
    parameter int NUM_COLS = 80
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tcw_pkg::REQ_W-1:0]   i_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_color,
    input  logic [tcw_pkg::IDX_W-1:0]   i_cell_index,
    output logic                        o_strobe,
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_data
);
    import tcw_pkg::*;

    localparam int SIZE = NUM_ROWS * NUM_COLS;
    localparam int AW   = $clog2(SIZE);
    localparam int RW   = $clog2(NUM_ROWS);
    localparam int CW   = $clog2(NUM_COLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SIZE - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(NUM_COLS);
    localparam logic [AW-1:0] BOT_ROW_A = AW'(SIZE - NUM_COLS);
    localparam logic [CW-1:0] LAST_COL  = CW'(NUM_COLS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(NUM_ROWS - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [AW-1:0]       r_row_base, n_row_base;
    logic [ATTR_W-1:0]   r_attr, n_attr;
    logic                r_strobe, n_strobe;
    logic [REQ_W-1:0]    r_req, n_req;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic [ATTR_W-1:0]   r_color, n_color;
    logic [IDX_W-1:0]    r_cidx, n_cidx;
    logic                r_hit, n_hit;
    logic [CELL_W-1:0]   r_fill, n_fill;
    logic [POS_W-1:0]    r_cursor_pos, n_cursor_pos;
    logic [CELL_W-1:0]   r_cell_data, n_cell_data;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;
    logic [AW-1:0]       addr_inc;

    tcw_cell_ram #(
        .DEPTH (SIZE),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared sweep incrementer
    assign addr_inc = r_addr + AW'(1);

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_col        = r_col;
        n_row        = r_row;
        n_row_base   = r_row_base;
        n_attr       = r_attr;
        n_strobe     = 1'b0;
        n_req        = r_req;
        n_char       = r_char;
        n_color      = r_color;
        n_cidx       = r_cidx;
        n_hit        = r_hit;
        n_fill       = r_fill;
        n_cursor_pos = r_cursor_pos;
        n_cell_data  = r_cell_data;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = r_fill;
        ram_raddr    = r_addr;

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = addr_inc;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req_type;
                    n_char  = i_char_code;
                    n_color = i_color;
                    n_cidx  = i_cell_index;
                    n_hit   = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_req)
                    REQ_WRITE: begin
                        if (r_char != CH_NUL) begin
                            if (r_char != CH_NEWLINE && r_char != CH_RETURN) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_row_base + AW'(r_col);
                                ram_wdata = {r_attr, r_char};
                            end
                            if (r_char == CH_NEWLINE || r_char == CH_RETURN
                                    || r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_addr  = COLS_A;
                                    n_state = S_SCR_RD;
                                end else begin
                                    n_row      = r_row + RW'(1);
                                    n_row_base = r_row_base + COLS_A;
                                end
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                    end
                    REQ_CLEAR: begin
                        n_attr     = r_color;
                        n_fill     = {r_color, CH_SPACE};
                        n_addr     = '0;
                        n_col      = '0;
                        n_row      = '0;
                        n_row_base = '0;
                        n_state    = S_FILL;
                    end
                    REQ_READ: begin
                        ram_raddr = AW'(r_cidx);
                        n_hit     = 32'(r_cidx) < 32'(SIZE);
                        n_state   = S_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD: begin
                ram_raddr = AW'(r_cidx);
                n_state   = S_DONE;
            end
            S_SCR_RD: begin
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr - COLS_A;
                ram_wdata = ram_rdata;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = BOT_ROW_A;
                    n_fill  = {r_attr, CH_SPACE};
                    n_state = S_FILL;
                end else begin
                    n_addr  = addr_inc;
                    n_state = S_SCR_RD;
                end
            end
            S_FILL: begin
                ram_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_DONE;
                end else begin
                    n_addr = addr_inc;
                end
            end
            S_DONE: begin
                n_strobe     = 1'b1;
                n_cursor_pos = POS_W'(r_row_base + AW'(r_col));
                n_cell_data  = (r_req == REQ_READ && r_hit) ? ram_rdata : '0;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_addr     <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
            r_attr     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_col      <= n_col;
            r_row      <= n_row;
            r_row_base <= n_row_base;
            r_attr     <= n_attr;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_char       <= n_char;
        r_color      <= n_color;
        r_cidx       <= n_cidx;
        r_hit        <= n_hit;
        r_fill       <= n_fill;
        r_cursor_pos <= n_cursor_pos;
        r_cell_data  <= n_cell_data;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_cursor_pos = r_cursor_pos;
    assign o_cell_data  = r_cell_data;

    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished request");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a request transfer");

    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR_WR) |-> $past(r_state == S_SCR_RD))
        else $error("scroll write without a preceding read");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < 32'(NUM_COLS)) && (32'(r_row) < 32'(NUM_ROWS)))
        else $error("cursor outside the screen");

endmodule

### hdl/tcw_cell_ram.sv
// tcw_cell_ram: screen cell store, one write port and one registered read port.
// Depends on tcw_pkg for the cell width.
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### verif/text_console_writer_tb.sv
// text_console_writer_tb: self-checking testbench for the text console writer.
// Depends on tcw_pkg and the text_console_writer RTL; predicts every result from
// its own screen store, cursor and attribute, and compares each strobed result.
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int NUM_ROWS     = 25;
    localparam int NUM_COLS     = 80;
    localparam int SCREEN_CELLS = NUM_ROWS * NUM_COLS;
    localparam int STALL_LIMIT  = 20000;
    localparam int MAX_REPORTS  = 20;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] cdata;
    } t_console_result;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic [REQ_W-1:0]   i_req_type   = REQ_WRITE;
    logic [CHAR_W-1:0]  i_char_code  = '0;
    logic [ATTR_W-1:0]  i_color      = '0;
    logic [IDX_W-1:0]   i_cell_index = '0;
    logic               o_strobe;
    logic [POS_W-1:0]   o_cursor_pos;
    logic [CELL_W-1:0]  o_cell_data;

    // screen predictor state
    logic [CELL_W-1:0]  screen_model [SCREEN_CELLS];
    logic [6:0]         col_model = '0;
    logic [4:0]         row_model = '0;
    logic [ATTR_W-1:0]  attr_model = '0;

    t_console_result    expected_results [$];

    int sender_idle_pct = 0;
    int stall_cycles    = 0;
    int n_sent          = 0;
    int n_accepted      = 0;
    int n_checked       = 0;
    int n_fail          = 0;
    int n_clear         = 0;
    int n_scroll        = 0;
    int n_read          = 0;
    int n_read_oob      = 0;

    text_console_writer #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_color      (i_color),
        .i_cell_index (i_cell_index),
        .o_strobe     (o_strobe),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_data  (o_cell_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < SCREEN_CELLS; i++) screen_model[i] = '0;
    end

    function automatic logic [POS_W-1:0] cursor_lin();
        int p;
        p = int'(row_model) * NUM_COLS + int'(col_model);
        return p[POS_W-1:0];
    endfunction

    task automatic advance_row();
        int i;
        col_model = '0;
        row_model = row_model + 1'b1;
        if (row_model >= NUM_ROWS) begin
            for (i = 0; i < SCREEN_CELLS - NUM_COLS; i++)
                screen_model[i] = screen_model[i + NUM_COLS];
            for (i = SCREEN_CELLS - NUM_COLS; i < SCREEN_CELLS; i++)
                screen_model[i] = {attr_model, CH_SPACE};
            row_model = row_model - 1'b1;
            n_scroll++;
        end
    endtask

    task automatic predict_console(input logic [REQ_W-1:0] rq, input logic [CHAR_W-1:0] ch,
                                   input logic [ATTR_W-1:0] clr, input logic [IDX_W-1:0] idx,
                                   output t_console_result res);
        int i;
        res.cdata = '0;
        case (rq)
            REQ_WRITE: begin
                if (ch == CH_NEWLINE || ch == CH_RETURN) begin
                    advance_row();
                end else if (ch != CH_NUL) begin
                    screen_model[cursor_lin()] = {attr_model, ch};
                    col_model = col_model + 1'b1;
                    if (col_model >= NUM_COLS) advance_row();
                end
            end
            REQ_CLEAR: begin
                attr_model = clr;
                for (i = 0; i < SCREEN_CELLS; i++) screen_model[i] = {attr_model, CH_SPACE};
                col_model = '0;
                row_model = '0;
                n_clear++;
            end
            REQ_READ: begin
                n_read++;
                if (idx < SCREEN_CELLS) res.cdata = screen_model[idx];
                else n_read_oob++;
            end
            default: ;
        endcase
        res.pos = cursor_lin();
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // result checking and prediction on every transfer
    always @(posedge i_clk) begin
        t_console_result want;
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                report_mismatch("o_strobe", 0, o_strobe);
            end else if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, cursor_pos", 0, o_cursor_pos);
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (o_cursor_pos !== want.pos)
                        report_mismatch("cursor_pos", want.pos, o_cursor_pos);
                    if (o_cell_data !== want.cdata)
                        report_mismatch("cell_data", want.cdata, o_cell_data);
                end
            end
            if (start && busy === 1'b0) begin
                predict_console(i_req_type, i_char_code, i_color, i_cell_index, want);
                expected_results.push_back(want);
                n_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // called just after a falling edge; returns just after the falling edge that
    // follows the transfer, with start still high
    task automatic send_req(input logic [REQ_W-1:0] rq, input logic [CHAR_W-1:0] ch,
                            input logic [ATTR_W-1:0] clr, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= rq;
        i_char_code  <= ch;
        i_color      <= clr;
        i_cell_index <= idx;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic send_write(input logic [CHAR_W-1:0] ch);
        send_req(REQ_WRITE, ch, ATTR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
    endtask

    task automatic send_clear(input logic [ATTR_W-1:0] clr);
        send_req(REQ_CLEAR, CHAR_W'($urandom_range(255)), clr, IDX_W'($urandom_range(2047)));
    endtask

    task automatic send_read(input logic [IDX_W-1:0] idx);
        send_req(REQ_READ, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), idx);
    endtask

    function automatic logic [CHAR_W-1:0] random_glyph();
        return CHAR_W'($urandom_range(255, 14));
    endfunction

    function automatic logic [IDX_W-1:0] recent_cell();
        logic [POS_W-1:0] p;
        p = cursor_lin();
        if ($urandom_range(1)) return (p == 0) ? '0 : p - 1'b1;
        return IDX_W'($urandom_range(2047));
    endfunction

    task automatic test_requests_and_specials();
        send_read('0);
        send_read(IDX_W'(SCREEN_CELLS - 1));
        send_read(IDX_W'(SCREEN_CELLS));
        send_read('1);
        send_req(REQ_UNUSED, 8'hff, 8'hff, '1);
        send_write(CH_NUL);
        send_req(REQ_WRITE, 8'h41, 8'hff, '0);     // color is ignored on a write
        send_write(8'hff);
        send_write(8'h01);
        send_read(IDX_W'(0));
        send_read(IDX_W'(1));
        send_read(IDX_W'(2));
        send_write(CH_RETURN);
        send_write(CH_NEWLINE);
        send_clear(8'ha5);
        send_read(IDX_W'(0));
        send_read(IDX_W'(SCREEN_CELLS - 1));
        send_write(8'h80);
        send_read(IDX_W'(0));
        send_clear(8'hff);
        send_write(8'h7f);
        send_read(IDX_W'(0));
        send_clear(8'h00);
        send_read(IDX_W'(SCREEN_CELLS - 1));
    endtask

    task automatic test_wrap_and_scroll();
        int i;
        send_clear(8'h1e);
        for (i = 0; i < NUM_ROWS - 1; i++) send_write(CH_NEWLINE);
        // full bottom row: the last write wraps and scrolls
        for (i = 0; i < NUM_COLS; i++) send_write(random_glyph());
        send_read(IDX_W'(SCREEN_CELLS - 2 * NUM_COLS));
        send_read(IDX_W'(SCREEN_CELLS - NUM_COLS - 1));
        send_read(IDX_W'(SCREEN_CELLS - NUM_COLS));
        send_read(IDX_W'(SCREEN_CELLS - 1));
        send_write(CH_RETURN);
        send_read(IDX_W'(SCREEN_CELLS - 2 * NUM_COLS));
        for (i = 0; i < 5; i++) send_write(random_glyph());
        send_read(IDX_W'(SCREEN_CELLS - NUM_COLS));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int stop_at;
        int len;
        int i;
        logic [REQ_W-1:0] rq;
        sender_idle_pct = idle_pct;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            if ($urandom_range(9) < 7) begin
                // a line of text, mostly short, now and then longer than a row
                len = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(100, 60);
                for (i = 0; i < len; i++) send_write(random_glyph());
                if ($urandom_range(3) != 0)
                    send_write($urandom_range(1) ? CH_NEWLINE : CH_RETURN);
                repeat ($urandom_range(2)) send_read(recent_cell());
            end else begin
                rq = REQ_W'($urandom_range(3));
                if (rq == REQ_CLEAR && $urandom_range(3) != 0) rq = REQ_READ;
                send_req(rq, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                         IDX_W'($urandom_range(2047)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_requests_and_specials();
        test_wrap_and_scroll();
        test_random_traffic(0, 165);
        test_random_traffic(60, 165);
        test_random_traffic(19, 165);

        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) n_fail++;

        $display("Checked %0d results for %0d requests, %0d mismatches.",
                 n_checked, n_accepted, n_fail);
        $display("Covered %0d clears, %0d scrolls, %0d reads (%0d out of range).",
                 n_clear, n_scroll, n_read, n_read_oob);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
hdl/tcw_pkg.sv
hdl/tcw_cell_ram.sv
hdl/text_console_writer.sv
verif/text_console_writer_tb.sv
